@@ src/prap_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prap_pkg
// Shared widths, angle constants, arctangent table and sideband type for the
// point rotation pipeline.
// ----------------------------------------------------------------------------
package prap_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int CORDIC_STAGES = 18;
  localparam int ANGLE_WIDTH   = 17;

  localparam int ANG_EXT_W = ANGLE_WIDTH + 1;
  localparam int CS_W      = 32;
  localparam int Z_W       = 32;
  localparam int Z_SHIFT   = 16;
  localparam int FRAC_CS   = 30;
  localparam int OFS_W     = COORD_WIDTH + 1;
  localparam int LO_W      = 16;
  localparam int HI_W      = OFS_W - LO_W;
  localparam int PH_W      = HI_W + CS_W;
  localparam int PL_W      = LO_W + 1 + CS_W;
  localparam int SH_W      = PH_W + 1;
  localparam int SL_W      = PL_W + 1;
  localparam int TOT_W     = OFS_W + CS_W + 3;
  localparam int Q_W       = TOT_W - FRAC_CS;
  localparam int SUM_W     = Q_W + 1;

  localparam int TURN_UNITS         = 46080;
  localparam int HALF_TURN_UNITS    = 23040;
  localparam int QUARTER_TURN_UNITS = 11520;
  localparam int INV_GAIN_Q30       = 652032874;
  localparam int ROUND_HALF_Q30     = 536870912;

  typedef struct packed {
    logic                    valid;
    logic                    flip;
    logic [OFS_W-1:0]        dx;
    logic [OFS_W-1:0]        dy;
    logic [COORD_WIDTH-1:0]  cx;
    logic [COORD_WIDTH-1:0]  cy;
  } prap_side_t;

  // atan(2^-i) in degrees, scaled by 2^23
  function automatic logic signed [Z_W-1:0] atan_q23(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:  v = Z_W'(377487360);
      1:  v = Z_W'(222843801);
      2:  v = Z_W'(117744544);
      3:  v = Z_W'(59768969);
      4:  v = Z_W'(30000467);
      5:  v = Z_W'(15014858);
      6:  v = Z_W'(7509261);
      7:  v = Z_W'(3754860);
      8:  v = Z_W'(1877459);
      9:  v = Z_W'(938733);
      10: v = Z_W'(469367);
      11: v = Z_W'(234683);
      12: v = Z_W'(117342);
      13: v = Z_W'(58671);
      14: v = Z_W'(29335);
      15: v = Z_W'(14668);
      16: v = Z_W'(7334);
      17: v = Z_W'(3667);
      18: v = Z_W'(1833);
      19: v = Z_W'(917);
      20: v = Z_W'(458);
      21: v = Z_W'(229);
      22: v = Z_W'(115);
      23: v = Z_W'(57);
      24: v = Z_W'(29);
      25: v = Z_W'(14);
      26: v = Z_W'(7);
      27: v = Z_W'(4);
      28: v = Z_W'(2);
      29: v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ src/prap_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prap_in_if / prap_out_if
// Valid/ready channels for points in and rotated points out.
// ----------------------------------------------------------------------------
interface prap_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [prap_pkg::COORD_WIDTH-1:0]  point_x;
  logic signed [prap_pkg::COORD_WIDTH-1:0]  point_y;
  logic signed [prap_pkg::COORD_WIDTH-1:0]  pivot_x;
  logic signed [prap_pkg::COORD_WIDTH-1:0]  pivot_y;
  logic signed [prap_pkg::ANGLE_WIDTH-1:0]  angle;

  modport source (output valid, point_x, point_y, pivot_x, pivot_y, angle, input ready);
  modport sink   (input valid, point_x, point_y, pivot_x, pivot_y, angle, output ready);
endinterface

interface prap_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [prap_pkg::COORD_WIDTH-1:0]  rotated_x;
  logic signed [prap_pkg::COORD_WIDTH-1:0]  rotated_y;

  modport source (output valid, rotated_x, rotated_y, input ready);
  modport sink   (input valid, rotated_x, rotated_y, output ready);
endinterface
`default_nettype wire

@@ src/point_rotate_about_pivot.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_rotate_about_pivot
// Rotates a Q16.16 point counter-clockwise about a pivot by an angle given in
// 1/128 degree steps, using a pipelined CORDIC for cosine and sine.
// ----------------------------------------------------------------------------
// The block takes one point per clock while the output is not held and
// returns one rotated point per point, in order. A point passes through
// angle folding and pivot offset, the CORDIC iterations, the half-turn sign
// fix, then split multiply, partial sum, rounding and pivot add with
// saturation. The whole pipeline advances together; it holds when a result
// is waiting and the output is not ready, and any empty slot at the end
// still lets a new point in. The angle is clamped to one full turn either
// way.
// ----------------------------------------------------------------------------
module point_rotate_about_pivot (
  input  wire         clk,
  input  wire         rst_n,
  prap_in_if.sink     in_ch,
  prap_out_if.source  out_ch
);

  localparam int CW = prap_pkg::COORD_WIDTH;
  localparam int AW = prap_pkg::ANG_EXT_W;

  localparam logic signed [AW-1:0] TURN_A    = AW'(prap_pkg::TURN_UNITS);
  localparam logic signed [AW-1:0] HALF_A    = AW'(prap_pkg::HALF_TURN_UNITS);
  localparam logic signed [AW-1:0] QUARTER_A = AW'(prap_pkg::QUARTER_TURN_UNITS);

  logic en;

  // stage 0: angle fold and offsets
  logic signed [AW-1:0]             ang;
  logic                             flip_nxt;
  logic signed [prap_pkg::Z_W-1:0]  z0_nxt;
  logic signed [prap_pkg::Z_W-1:0]  z0_r;
  prap_pkg::prap_side_t             s0_r;

  always_comb begin
    ang      = AW'(in_ch.angle);
    flip_nxt = 1'b0;
    if (ang > TURN_A) begin
      ang = TURN_A;
    end
    if (ang < -TURN_A) begin
      ang = -TURN_A;
    end
    if (ang > HALF_A) begin
      ang = ang - TURN_A;
    end
    if (ang < -HALF_A) begin
      ang = ang + TURN_A;
    end
    if (ang > QUARTER_A) begin
      ang      = ang - HALF_A;
      flip_nxt = 1'b1;
    end
    if (ang < -QUARTER_A) begin
      ang      = ang + HALF_A;
      flip_nxt = 1'b1;
    end
    z0_nxt = prap_pkg::Z_W'(ang) <<< prap_pkg::Z_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.valid <= 1'b0;
    end else if (en) begin
      s0_r.valid <= in_ch.valid;
    end
    if (en) begin
      z0_r      <= z0_nxt;
      s0_r.flip <= flip_nxt;
      s0_r.dx   <= prap_pkg::OFS_W'(in_ch.point_x) - prap_pkg::OFS_W'(in_ch.pivot_x);
      s0_r.dy   <= prap_pkg::OFS_W'(in_ch.point_y) - prap_pkg::OFS_W'(in_ch.pivot_y);
      s0_r.cx   <= in_ch.pivot_x;
      s0_r.cy   <= in_ch.pivot_y;
    end
  end

  // cordic
  logic signed [prap_pkg::CS_W-1:0] cos_w;
  logic signed [prap_pkg::CS_W-1:0] sin_w;
  prap_pkg::prap_side_t             sc_w;

  prap_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .z_i    (z0_r),
    .side_i (s0_r),
    .cos_o  (cos_w),
    .sin_o  (sin_w),
    .side_o (sc_w)
  );

  // m1: split partial products
  logic signed [prap_pkg::HI_W-1:0]   dxh;
  logic signed [prap_pkg::HI_W-1:0]   dyh;
  logic signed [prap_pkg::LO_W:0]     dxl;
  logic signed [prap_pkg::LO_W:0]     dyl;

  assign dxh = $signed(sc_w.dx[prap_pkg::OFS_W-1:prap_pkg::LO_W]);
  assign dyh = $signed(sc_w.dy[prap_pkg::OFS_W-1:prap_pkg::LO_W]);
  assign dxl = $signed({1'b0, sc_w.dx[prap_pkg::LO_W-1:0]});
  assign dyl = $signed({1'b0, sc_w.dy[prap_pkg::LO_W-1:0]});

  logic signed [prap_pkg::PH_W-1:0] xc_h_r, ys_h_r, xs_h_r, yc_h_r;
  logic signed [prap_pkg::PL_W-1:0] xc_l_r, ys_l_r, xs_l_r, yc_l_r;
  logic [CW-1:0]                    m1_cx_r, m1_cy_r;
  logic                             m1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= sc_w.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xc_h_r  <= dxh * cos_w;
      ys_h_r  <= dyh * sin_w;
      xs_h_r  <= dxh * sin_w;
      yc_h_r  <= dyh * cos_w;
      xc_l_r  <= dxl * cos_w;
      ys_l_r  <= dyl * sin_w;
      xs_l_r  <= dxl * sin_w;
      yc_l_r  <= dyl * cos_w;
      m1_cx_r <= sc_w.cx;
      m1_cy_r <= sc_w.cy;
    end
  end

  // m2: combine partial products
  logic signed [prap_pkg::SH_W-1:0] rx_h_r, ry_h_r;
  logic signed [prap_pkg::SL_W-1:0] rx_l_r, ry_l_r;
  logic [CW-1:0]                    m2_cx_r, m2_cy_r;
  logic                             m2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else if (en) begin
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_h_r  <= prap_pkg::SH_W'(xc_h_r) - prap_pkg::SH_W'(ys_h_r);
      ry_h_r  <= prap_pkg::SH_W'(xs_h_r) + prap_pkg::SH_W'(yc_h_r);
      rx_l_r  <= prap_pkg::SL_W'(xc_l_r) - prap_pkg::SL_W'(ys_l_r);
      ry_l_r  <= prap_pkg::SL_W'(xs_l_r) + prap_pkg::SL_W'(yc_l_r);
      m2_cx_r <= m1_cx_r;
      m2_cy_r <= m1_cy_r;
    end
  end

  // m3: full sum, round half up, drop fraction
  logic signed [prap_pkg::TOT_W-1:0] tot_x;
  logic signed [prap_pkg::TOT_W-1:0] tot_y;
  logic signed [prap_pkg::Q_W-1:0]   qx_r, qy_r;
  logic [CW-1:0]                     m3_cx_r, m3_cy_r;
  logic                              m3_v_r;

  assign tot_x = (prap_pkg::TOT_W'(rx_h_r) <<< prap_pkg::LO_W) + prap_pkg::TOT_W'(rx_l_r)
               + prap_pkg::TOT_W'(prap_pkg::ROUND_HALF_Q30);
  assign tot_y = (prap_pkg::TOT_W'(ry_h_r) <<< prap_pkg::LO_W) + prap_pkg::TOT_W'(ry_l_r)
               + prap_pkg::TOT_W'(prap_pkg::ROUND_HALF_Q30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_v_r <= 1'b0;
    end else if (en) begin
      m3_v_r <= m2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qx_r    <= tot_x[prap_pkg::TOT_W-1:prap_pkg::FRAC_CS];
      qy_r    <= tot_y[prap_pkg::TOT_W-1:prap_pkg::FRAC_CS];
      m3_cx_r <= m2_cx_r;
      m3_cy_r <= m2_cy_r;
    end
  end

  // m4: pivot add and saturation into the output register
  logic signed [prap_pkg::SUM_W-1:0] sum_x;
  logic signed [prap_pkg::SUM_W-1:0] sum_y;
  logic signed [CW-1:0]              sat_x;
  logic signed [CW-1:0]              sat_y;
  logic signed [CW-1:0]              rot_x_r, rot_y_r;
  logic                              out_v_r;

  assign sum_x = prap_pkg::SUM_W'(qx_r) + prap_pkg::SUM_W'($signed(m3_cx_r));
  assign sum_y = prap_pkg::SUM_W'(qy_r) + prap_pkg::SUM_W'($signed(m3_cy_r));

  always_comb begin
    if (sum_x[prap_pkg::SUM_W-1:CW-1] == '0 || sum_x[prap_pkg::SUM_W-1:CW-1] == '1) begin
      sat_x = sum_x[CW-1:0];
    end else begin
      sat_x = sum_x[prap_pkg::SUM_W-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
    if (sum_y[prap_pkg::SUM_W-1:CW-1] == '0 || sum_y[prap_pkg::SUM_W-1:CW-1] == '1) begin
      sat_y = sum_y[CW-1:0];
    end else begin
      sat_y = sum_y[prap_pkg::SUM_W-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= m3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_x_r <= sat_x;
      rot_y_r <= sat_y;
    end
  end

  // pipeline advances unless a result is held by the sink
  assign en = !out_v_r || out_ch.ready;

  assign in_ch.ready      = en;
  assign out_ch.valid     = out_v_r;
  assign out_ch.rotated_x = rot_x_r;
  assign out_ch.rotated_y = rot_y_r;

endmodule
`default_nettype wire

@@ src/prap_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prap_cordic
// Unrolled rotation-mode CORDIC, one register stage per iteration, followed by
// a stage that applies the half-turn sign flip. Sideband rides along.
// ----------------------------------------------------------------------------
module prap_cordic (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                en,
  input  wire logic signed [prap_pkg::Z_W-1:0] z_i,
  input  wire prap_pkg::prap_side_t          side_i,
  output logic signed [prap_pkg::CS_W-1:0]   cos_o,
  output logic signed [prap_pkg::CS_W-1:0]   sin_o,
  output prap_pkg::prap_side_t               side_o
);

  localparam int N = prap_pkg::CORDIC_STAGES;

  logic signed [prap_pkg::CS_W-1:0] x_r [1:N];
  logic signed [prap_pkg::CS_W-1:0] y_r [1:N];
  logic signed [prap_pkg::Z_W-1:0]  z_r [1:N];
  prap_pkg::prap_side_t             sd_r [1:N];

  logic signed [prap_pkg::CS_W-1:0] c_r;
  logic signed [prap_pkg::CS_W-1:0] s_r;
  prap_pkg::prap_side_t             so_r;

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic signed [prap_pkg::CS_W-1:0] xi;
    logic signed [prap_pkg::CS_W-1:0] yi;
    logic signed [prap_pkg::Z_W-1:0]  zi;
    prap_pkg::prap_side_t             si;
    logic signed [prap_pkg::CS_W-1:0] x_nxt;
    logic signed [prap_pkg::CS_W-1:0] y_nxt;
    logic signed [prap_pkg::Z_W-1:0]  z_nxt;

    if (g == 0) begin : g_first
      assign xi = prap_pkg::CS_W'(prap_pkg::INV_GAIN_Q30);
      assign yi = '0;
      assign zi = z_i;
      assign si = side_i;
    end else begin : g_mid
      assign xi = x_r[g];
      assign yi = y_r[g];
      assign zi = z_r[g];
      assign si = sd_r[g];
    end

    always_comb begin
      if (!zi[prap_pkg::Z_W-1]) begin
        x_nxt = xi - (yi >>> g);
        y_nxt = yi + (xi >>> g);
        z_nxt = zi - prap_pkg::atan_q23(g);
      end else begin
        x_nxt = xi + (yi >>> g);
        y_nxt = yi - (xi >>> g);
        z_nxt = zi + prap_pkg::atan_q23(g);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sd_r[g+1].valid <= 1'b0;
      end else if (en) begin
        sd_r[g+1].valid <= si.valid;
      end
      if (en) begin
        x_r[g+1]       <= x_nxt;
        y_r[g+1]       <= y_nxt;
        z_r[g+1]       <= z_nxt;
        sd_r[g+1].flip <= si.flip;
        sd_r[g+1].dx   <= si.dx;
        sd_r[g+1].dy   <= si.dy;
        sd_r[g+1].cx   <= si.cx;
        sd_r[g+1].cy   <= si.cy;
      end
    end
  end

  // half-turn fold correction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      so_r.valid <= 1'b0;
    end else if (en) begin
      so_r.valid <= sd_r[N].valid;
    end
    if (en) begin
      c_r        <= sd_r[N].flip ? -x_r[N] : x_r[N];
      s_r        <= sd_r[N].flip ? -y_r[N] : y_r[N];
      so_r.flip  <= sd_r[N].flip;
      so_r.dx    <= sd_r[N].dx;
      so_r.dy    <= sd_r[N].dy;
      so_r.cx    <= sd_r[N].cx;
      so_r.cy    <= sd_r[N].cy;
    end
  end

  assign cos_o  = c_r;
  assign sin_o  = s_r;
  assign side_o = so_r;

endmodule
`default_nettype wire

@@ dv/tb_point_rotate_about_pivot.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_rotate_about_pivot
// Streams points, pivots and angles through the rotator and compares every
// rotated point with a bit-exact CORDIC prediction computed at input
// transfer. Directed corners of angle folding and saturation come first,
// then random points under changing sender and receiver stall patterns.
// ----------------------------------------------------------------------------
module tb_point_rotate_about_pivot;

  localparam int RANDOM_ITEMS = 1300;
  localparam int DRAIN_CYCLES = 50;
  localparam int MAX_REPORTS  = 10;

  localparam int PHASE_RECV_STALL = 0;
  localparam int PHASE_SEND_STALL = 1;
  localparam int PHASE_FREE       = 2;

  localparam int CW   = prap_pkg::COORD_WIDTH;
  localparam int AGW  = prap_pkg::ANGLE_WIDTH;
  localparam int TURN = prap_pkg::TURN_UNITS;
  localparam int HALF = prap_pkg::HALF_TURN_UNITS;
  localparam int QTR  = prap_pkg::QUARTER_TURN_UNITS;

  typedef logic signed [95:0] wide_t;

  typedef struct {
    logic signed [CW-1:0]  point_x;
    logic signed [CW-1:0]  point_y;
    logic signed [CW-1:0]  pivot_x;
    logic signed [CW-1:0]  pivot_y;
    logic signed [AGW-1:0] angle;
  } point_item_t;

  typedef struct {
    logic signed [CW-1:0] rotated_x;
    logic signed [CW-1:0] rotated_y;
  } rotated_point_t;

  // atan(2^-i) in degrees, 2^-23 degree per lsb
  localparam longint ATAN_DEG[32] = '{
    377487360, 222843801, 117744544, 59768969, 30000467, 15014858,
    7509261, 3754860, 1877459, 938733, 469367, 234683, 117342, 58671,
    29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
    4, 2, 1, 0, 0
  };

  logic clk;
  logic rst_n;

  prap_in_if  in_ch();
  prap_out_if out_ch();

  point_rotate_about_pivot u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  point_item_t    pending_points[$];
  rotated_point_t expected_rotations[$];
  point_item_t    driven_point;
  int             accepted_points;
  int             points_total;
  int             stall_phase;
  int             mismatches;

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic rotated_point_t predict_rotation(point_item_t p);
    longint         ang;
    longint         zacc;
    longint         cos_q;
    longint         sin_q;
    longint         cs;
    longint         sn;
    bit             flip;
    int             i;
    wide_t          dx;
    wide_t          dy;
    wide_t          rx;
    wide_t          ry;
    wide_t          cmax;
    wide_t          cmin;
    rotated_point_t r;
    ang = p.angle;
    flip = 1'b0;
    if (ang > TURN) ang = TURN;
    if (ang < -TURN) ang = -TURN;
    if (ang > HALF) ang -= TURN;
    if (ang < -HALF) ang += TURN;
    if (ang > QTR) begin
      ang -= HALF;
      flip = 1'b1;
    end
    if (ang < -QTR) begin
      ang += HALF;
      flip = 1'b1;
    end
    zacc = ang * 65536;
    cos_q = prap_pkg::INV_GAIN_Q30;
    sin_q = 0;
    for (i = 0; i < prap_pkg::CORDIC_STAGES; i++) begin
      cs = cos_q >>> (i & 31);
      sn = sin_q >>> (i & 31);
      if (zacc >= 0) begin
        cos_q -= sn;
        sin_q += cs;
        zacc -= ATAN_DEG[i & 31];
      end else begin
        cos_q += sn;
        sin_q -= cs;
        zacc += ATAN_DEG[i & 31];
      end
    end
    if (flip) begin
      cos_q = -cos_q;
      sin_q = -sin_q;
    end
    dx = p.point_x;
    dx = dx - p.pivot_x;
    dy = p.point_y;
    dy = dy - p.pivot_y;
    rx = ((dx * cos_q - dy * sin_q + prap_pkg::ROUND_HALF_Q30) >>> prap_pkg::FRAC_CS)
         + p.pivot_x;
    ry = ((dx * sin_q + dy * cos_q + prap_pkg::ROUND_HALF_Q30) >>> prap_pkg::FRAC_CS)
         + p.pivot_y;
    cmax = (wide_t'(1) <<< (CW - 1)) - 1;
    cmin = -cmax - 1;
    if (rx > cmax) rx = cmax;
    if (rx < cmin) rx = cmin;
    if (ry > cmax) ry = cmax;
    if (ry < cmin) ry = cmin;
    r.rotated_x = rx[CW-1:0];
    r.rotated_y = ry[CW-1:0];
    return r;
  endfunction

  task automatic add_point(input int px, input int py, input int cx, input int cy,
                           input int ang);
    point_item_t p;
    p.point_x = px;
    p.point_y = py;
    p.pivot_x = cx;
    p.pivot_y = cy;
    p.angle   = AGW'(ang);
    pending_points.push_back(p);
  endtask

  function automatic int random_coord();
    int v;
    case ($urandom_range(4))
      0: v = int'($urandom());
      1: v = int'($urandom_range(2097152)) - 1048576;
      2: v = int'($urandom_range(1 << 29)) - (1 << 28);
      3: v = $urandom_range(1) ? 32'h7fffffff - int'($urandom_range(255))
                               : 32'h80000000 + int'($urandom_range(255));
      default: v = int'($urandom_range(8388608)) - 4194304;
    endcase
    return v;
  endfunction

  function automatic int random_angle();
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: v = int'($urandom_range(2 * TURN)) - TURN;
      6: v = int'($urandom_range(131071)) - 65536;
      7, 8: begin
        v = QTR * int'($urandom_range(4)) + int'($urandom_range(2)) - 1;
        if ($urandom_range(1)) v = -v;
      end
      default: v = 128 * (int'($urandom_range(720)) - 360);
    endcase
    return v;
  endfunction

  function automatic int send_idle_pct(int ph);
    return (ph == PHASE_RECV_STALL) ? 30 : (ph == PHASE_SEND_STALL) ? 82 : 0;
  endfunction

  function automatic int recv_idle_pct(int ph);
    return (ph == PHASE_RECV_STALL) ? 82 : (ph == PHASE_SEND_STALL) ? 30 : 0;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      stall_phase <= PHASE_RECV_STALL;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_rotations.push_back(predict_rotation(driven_point));
        accepted_points++;
      end
      if (accepted_points >= (2 * points_total) / 3) begin
        stall_phase <= PHASE_FREE;
      end else if (accepted_points >= points_total / 3) begin
        stall_phase <= PHASE_SEND_STALL;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_points.size() != 0 &&
            $urandom_range(99) >= send_idle_pct(stall_phase)) begin
          driven_point = pending_points.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.point_x <= driven_point.point_x;
          in_ch.point_y <= driven_point.point_y;
          in_ch.pivot_x <= driven_point.pivot_x;
          in_ch.pivot_y <= driven_point.pivot_y;
          in_ch.angle   <= driven_point.angle;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rotated_point_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_rotations.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("unexpected result x=%0d y=%0d", out_ch.rotated_x, out_ch.rotated_y);
          end
        end else begin
          exp_r = expected_rotations.pop_front();
          if (out_ch.rotated_x !== exp_r.rotated_x || out_ch.rotated_y !== exp_r.rotated_y) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("mismatch: expected x=%0d y=%0d, actual x=%0d y=%0d",
                       exp_r.rotated_x, exp_r.rotated_y,
                       out_ch.rotated_x, out_ch.rotated_y);
            end
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct(stall_phase));
    end
  end

  initial begin
    int n;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.point_x   = '0;
    in_ch.point_y   = '0;
    in_ch.pivot_x   = '0;
    in_ch.pivot_y   = '0;
    in_ch.angle     = '0;
    out_ch.ready    = 1'b0;
    accepted_points = 0;
    mismatches      = 0;
    stall_phase     = PHASE_RECV_STALL;

    // angle folding, clamping and saturation corners
    add_point(32'h00010000, 0, 0, 0, 0);
    add_point(32'h00010000, 0, 0, 0, QTR);
    add_point(32'h00010000, 0, 0, 0, -QTR);
    add_point(32'h00010000, 32'h00020000, 0, 0, HALF);
    add_point(32'h00010000, 32'h00020000, 0, 0, -HALF);
    add_point(32'h00030000, 32'hfffe0000, 0, 0, TURN);
    add_point(32'h00030000, 32'hfffe0000, 0, 0, -TURN);
    add_point(32'h00050000, 32'h00010000, 32'h00010000, 0, 65535);
    add_point(32'h00050000, 32'h00010000, 32'h00010000, 0, -65536);
    add_point(32'h00100000, 32'h00100000, 0, 0, QTR + 1);
    add_point(32'h00100000, 32'h00100000, 0, 0, -QTR - 1);
    add_point(32'h00100000, 32'hfff00000, 0, 0, HALF + 1);
    add_point(32'h00100000, 32'hfff00000, 0, 0, -HALF - 1);
    add_point(32'h00070000, 32'h00020000, 0, 0, 3 * QTR);
    add_point(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, HALF);
    add_point(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0);
    add_point(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, HALF);
    add_point(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, QTR);
    add_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 5000);
    add_point(32'h80000000, 32'h80000000, 0, 0, 128);
    add_point(0, 0, 32'h7fffffff, 0, -QTR);
    add_point(1, 0, 0, 0, 6000);
    add_point(-1, -1, 0, 0, 1);
    add_point(32'h7fffffff, 32'h80000000, 32'h12345678, 32'hedcba987, 64);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      add_point(random_coord(), random_coord(), random_coord(), random_coord(),
                random_angle());
    end
    points_total = pending_points.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_points.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_rotations.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += expected_rotations.size();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
src/prap_pkg.sv
src/prap_if.sv
src/prap_cordic.sv
src/point_rotate_about_pivot.sv
dv/tb_point_rotate_about_pivot.sv
